/* rtl/core/dfr_pkg.sv */
// package for the delimited frame receiver: ring sizes, command and result
// codes, register map, shared structs and pointer helpers
// no dependencies
package dfr_pkg;

  // ring geometry: a ring holds at most RING_DEPTH-1 bytes
  localparam int RING_DEPTH = 64;
  localparam int PTR_W      = 6;
  localparam logic [PTR_W:0] DEPTH_C = (PTR_W + 1)'(RING_DEPTH);

  // configuration port
  localparam int CFG_AW = 4;
  localparam int CFG_DW = 32;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_HEAD   = 2'd1,
    REG_TAIL   = 2'd2,
    REG_NOTIFY = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_RECV  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_FLUSH = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  localparam logic [2:0] KIND_RECV    = 3'd0;
  localparam logic [2:0] KIND_RDATA   = 3'd1;
  localparam logic [2:0] KIND_REMPTY  = 3'd2;
  localparam logic [2:0] KIND_FBYTE   = 3'd3;
  localparam logic [2:0] KIND_FEMPTY  = 3'd4;
  localparam logic [2:0] KIND_FLUSHED = 3'd5;

  // register contents handed to the sequencer
  typedef struct packed {
    logic       mode_select;
    logic [7:0] head_byte;
    logic [7:0] tail_byte;
    logic       notify_enable;
  } cfg_t;

  // store access request from the sequencer
  typedef struct packed {
    logic             rd_en;
    logic             rd_stream;
    logic [PTR_W-1:0] rd_addr;
    logic             we_frame;
    logic             we_stream;
    logic [PTR_W-1:0] wr_addr;
    logic [7:0]       wr_data;
  } mem_req_t;

  // pointer advance with wrap at the ring depth
  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    logic [PTR_W:0] n;
    n = {1'b0, p} + (PTR_W + 1)'(1);
    ring_next = (n >= DEPTH_C) ? '0 : n[PTR_W-1:0];
  endfunction

  // bytes held between read and write pointer
  function automatic logic [PTR_W-1:0] ring_count(input logic [PTR_W-1:0] w,
                                                  input logic [PTR_W-1:0] r);
    logic [PTR_W:0] d;
    if (w >= r) begin
      d = {1'b0, w} - {1'b0, r};
    end else begin
      d = {1'b0, w} + DEPTH_C - {1'b0, r};
    end
    ring_count = d[PTR_W-1:0];
  endfunction

endpackage

/* rtl/core/dfr_if.sv */
// valid/ready channel interfaces for command beats and result beats
// depends on dfr_pkg for the pointer width
interface dfr_in_if import dfr_pkg::*;;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] rx_byte;

  modport source (output valid, command, rx_byte, input ready);
  modport sink   (input valid, command, rx_byte, output ready);
endinterface

interface dfr_out_if import dfr_pkg::*;;
  logic             valid;
  logic             ready;
  logic [2:0]       kind;
  logic [7:0]       data_byte;
  logic [PTR_W-1:0] occupancy;
  logic             last_of_run;
  logic             byte_dropped;
  logic             in_frame;

  modport source (output valid, kind, data_byte, occupancy, last_of_run,
                  byte_dropped, in_frame, input ready);
  modport sink   (input valid, kind, data_byte, occupancy, last_of_run,
                  byte_dropped, in_frame, output ready);
endinterface

/* rtl/core/dfr_cfg.sv */
// APB-style register block: mode, head byte, tail byte, notify enable
// depends on dfr_pkg
module dfr_cfg import dfr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign cfg_pready = 1'b1;
  assign idx        = reg_idx_t'(cfg_paddr[3:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg        = cfg_r;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_MODE:   cfg_nxt.mode_select   = cfg_pwdata[0];
        REG_HEAD:   cfg_nxt.head_byte     = cfg_pwdata[7:0];
        REG_TAIL:   cfg_nxt.tail_byte     = cfg_pwdata[7:0];
        REG_NOTIFY: cfg_nxt.notify_enable = cfg_pwdata[0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (idx)
      REG_MODE:   cfg_prdata = CFG_DW'(cfg_r.mode_select);
      REG_HEAD:   cfg_prdata = CFG_DW'(cfg_r.head_byte);
      REG_TAIL:   cfg_prdata = CFG_DW'(cfg_r.tail_byte);
      REG_NOTIFY: cfg_prdata = CFG_DW'(cfg_r.notify_enable);
      default:    cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

/* rtl/core/dfr_store.sv */
// frame and stream byte stores, one write port each and a shared
// registered read port; depends on dfr_pkg
module dfr_store import dfr_pkg::*; (
  input  logic       clk,
  input  mem_req_t   req,
  output logic [7:0] rd_data
);

  logic [7:0] frame_mem  [RING_DEPTH];
  logic [7:0] stream_mem [RING_DEPTH];
  logic [7:0] rd_data_r;

  assign rd_data = rd_data_r;

  // writes
  always_ff @(posedge clk) begin
    if (req.we_frame) begin
      frame_mem[req.wr_addr] <= req.wr_data;
    end
    if (req.we_stream) begin
      stream_mem[req.wr_addr] <= req.wr_data;
    end
  end

  // registered read, data holds until the next read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data_r <= req.rd_stream ? stream_mem[req.rd_addr] : frame_mem[req.rd_addr];
    end
  end

endmodule

/* rtl/core/dfr_ctrl.sv */
// command sequencer: ring pointers, frame tracking, frame drain and the
// result register; depends on dfr_pkg and the channel interfaces
module dfr_ctrl import dfr_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  cfg_t          cfg,
  input  logic [7:0]    rd_data,
  output mem_req_t      mreq,
  dfr_in_if.sink        in_chan,
  dfr_out_if.source     out_chan
);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_DRAIN = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  cmd_t             cmd_r, cmd_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic [PTR_W-1:0] fwp_r, fwp_nxt, frp_r, frp_nxt;
  logic [PTR_W-1:0] swp_r, swp_nxt, srp_r, srp_nxt;
  logic [PTR_W-1:0] pc_r, pc_nxt;
  logic             recv_r, recv_nxt;

  // result register
  logic             ov_r, ov_nxt;
  logic [2:0]       okind_r, okind_nxt;
  logic [7:0]       odata_r, odata_nxt;
  logic [PTR_W-1:0] oocc_r, oocc_nxt;
  logic             olast_r, olast_nxt;
  logic             odrop_r, odrop_nxt;
  logic             oinf_r, oinf_nxt;

  // working values
  logic             out_free;
  logic [PTR_W-1:0] act_wp, act_rp;
  logic [PTR_W-1:0] fnx, snx, frp_adv, act_rp_adv;
  logic [PTR_W-1:0] fcnt, scnt, drain_occ;
  logic             ffull, sfull;

  assign in_chan.ready      = (state_r == S_IDLE);
  assign out_chan.valid     = ov_r;
  assign out_chan.kind      = okind_r;
  assign out_chan.data_byte = odata_r;
  assign out_chan.occupancy = oocc_r;
  assign out_chan.last_of_run  = olast_r;
  assign out_chan.byte_dropped = odrop_r;
  assign out_chan.in_frame     = oinf_r;

  assign out_free   = !ov_r || out_chan.ready;
  assign act_wp     = cfg.mode_select ? swp_r : fwp_r;
  assign act_rp     = cfg.mode_select ? srp_r : frp_r;
  assign act_rp_adv = ring_next(act_rp);
  assign fnx        = ring_next(fwp_r);
  assign snx        = ring_next(swp_r);
  assign frp_adv    = ring_next(frp_r);
  assign ffull      = (fnx == frp_r);
  assign sfull      = (snx == srp_r);
  assign fcnt       = ring_count(fwp_r, frp_r);
  assign scnt       = ring_count(swp_r, srp_r);
  assign drain_occ  = ring_count(fwp_r, frp_adv);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    byte_nxt  = byte_r;
    fwp_nxt   = fwp_r;
    frp_nxt   = frp_r;
    swp_nxt   = swp_r;
    srp_nxt   = srp_r;
    pc_nxt    = pc_r;
    recv_nxt  = recv_r;
    mreq      = '0;
    mreq.wr_data = byte_r;

    ov_nxt    = ov_r && !out_chan.ready;
    okind_nxt = okind_r;
    odata_nxt = odata_r;
    oocc_nxt  = oocc_r;
    olast_nxt = olast_r;
    odrop_nxt = odrop_r;
    oinf_nxt  = oinf_r;

    unique case (state_r)
      // take a command beat and start the read at the active read pointer
      S_IDLE: begin
        if (in_chan.valid) begin
          cmd_nxt        = cmd_t'(in_chan.command);
          byte_nxt       = in_chan.rx_byte;
          mreq.rd_en     = 1'b1;
          mreq.rd_stream = cfg.mode_select;
          mreq.rd_addr   = act_rp;
          state_nxt      = S_EXEC;
        end
      end

      // read data is back: update state and load one result (none for a nop)
      S_EXEC: begin
        if (out_free) begin
          state_nxt = S_IDLE;
          okind_nxt = KIND_RECV;
          odata_nxt = '0;
          olast_nxt = 1'b1;
          odrop_nxt = 1'b0;
          oinf_nxt  = recv_r;
          unique case (cmd_r)
            CMD_RECV: begin
              ov_nxt = 1'b1;
              if (cfg.mode_select) begin
                // stream receive
                if (sfull) begin
                  odrop_nxt = 1'b1;
                  oocc_nxt  = scnt;
                end else begin
                  mreq.we_stream = 1'b1;
                  mreq.wr_addr   = swp_r;
                  swp_nxt        = snx;
                  oocc_nxt       = ring_count(snx, srp_r);
                end
              end else if (ffull) begin
                // full frame ring ignores every byte
                odrop_nxt = 1'b1;
                oocc_nxt  = fcnt;
              end else if (!recv_r) begin
                // waiting for the head byte
                if (byte_r == cfg.head_byte) begin
                  recv_nxt = 1'b1;
                  oinf_nxt = 1'b1;
                end
                oocc_nxt = fcnt;
              end else if (byte_r == cfg.tail_byte) begin
                // frame close
                recv_nxt = 1'b0;
                oinf_nxt = 1'b0;
                oocc_nxt = '0;
                if (cfg.notify_enable && (pc_r == fcnt) && (fcnt != '0)) begin
                  okind_nxt = KIND_FBYTE;
                  odata_nxt = rd_data;
                  oocc_nxt  = drain_occ;
                  olast_nxt = (drain_occ == '0);
                  if (drain_occ == '0) begin
                    pc_nxt  = '0;
                    fwp_nxt = '0;
                    frp_nxt = '0;
                  end else begin
                    frp_nxt      = frp_adv;
                    mreq.rd_en   = 1'b1;
                    mreq.rd_addr = frp_adv;
                    state_nxt    = S_DRAIN;
                  end
                end else begin
                  if (cfg.notify_enable && (pc_r == fcnt)) begin
                    okind_nxt = KIND_FEMPTY;
                  end
                  pc_nxt  = '0;
                  fwp_nxt = '0;
                  frp_nxt = '0;
                end
              end else if (byte_r != cfg.head_byte) begin
                // payload byte
                mreq.we_frame = 1'b1;
                mreq.wr_addr  = fwp_r;
                fwp_nxt       = fnx;
                pc_nxt        = pc_r + PTR_W'(1);
                oocc_nxt      = ring_count(fnx, frp_r);
              end else begin
                // repeated head byte
                oocc_nxt = fcnt;
              end
            end

            CMD_READ: begin
              ov_nxt = 1'b1;
              if (act_wp == act_rp) begin
                okind_nxt = KIND_REMPTY;
                oocc_nxt  = '0;
              end else begin
                okind_nxt = KIND_RDATA;
                odata_nxt = rd_data;
                oocc_nxt  = ring_count(act_wp, act_rp_adv);
                if (cfg.mode_select) begin
                  srp_nxt = act_rp_adv;
                end else begin
                  frp_nxt = act_rp_adv;
                end
              end
            end

            CMD_FLUSH: begin
              ov_nxt    = 1'b1;
              okind_nxt = KIND_FLUSHED;
              oocc_nxt  = '0;
              if (cfg.mode_select) begin
                swp_nxt = '0;
                srp_nxt = '0;
              end else begin
                fwp_nxt = '0;
                frp_nxt = '0;
              end
            end

            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end

      // frame drain, one byte a beat, oldest first
      S_DRAIN: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = KIND_FBYTE;
          odata_nxt = rd_data;
          oocc_nxt  = drain_occ;
          olast_nxt = (drain_occ == '0);
          odrop_nxt = 1'b0;
          oinf_nxt  = 1'b0;
          if (drain_occ == '0) begin
            pc_nxt    = '0;
            fwp_nxt   = '0;
            frp_nxt   = '0;
            state_nxt = S_IDLE;
          end else begin
            frp_nxt      = frp_adv;
            mreq.rd_en   = 1'b1;
            mreq.rd_addr = frp_adv;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fwp_r   <= '0;
      frp_r   <= '0;
      swp_r   <= '0;
      srp_r   <= '0;
      pc_r    <= '0;
      recv_r  <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fwp_r   <= fwp_nxt;
      frp_r   <= frp_nxt;
      swp_r   <= swp_nxt;
      srp_r   <= srp_nxt;
      pc_r    <= pc_nxt;
      recv_r  <= recv_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    byte_r  <= byte_nxt;
    okind_r <= okind_nxt;
    odata_r <= odata_nxt;
    oocc_r  <= oocc_nxt;
    olast_r <= olast_nxt;
    odrop_r <= odrop_nxt;
    oinf_r  <= oinf_nxt;
  end

endmodule

/* rtl/core/delimited_frame_receiver_fifo_unit.sv */
// a command beat's result is valid once the store read started at the
// accepting edge returns and the execute state loads the result register,
// held off while an untaken beat waits; no new command is taken until then.
// a frame drain gives one byte per cycle while the result beat is taken.
// synchronous active-low reset clears pointers, frame state, result valid
// and config registers; store contents and result payload registers stay.
module delimited_frame_receiver_fifo_unit import dfr_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  dfr_in_if.sink            in_chan,
  dfr_out_if.source         out_chan,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  cfg_t       cfg;
  mem_req_t   mreq;
  logic [7:0] rd_data;

  // register block
  dfr_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  // byte stores
  dfr_store u_store (
    .clk     (clk),
    .req     (mreq),
    .rd_data (rd_data)
  );

  // sequencer
  dfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .rd_data  (rd_data),
    .mreq     (mreq),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

endmodule
